// File: hdl/mbfr_pkg.sv
// Package for the MSB-first bit field reader: buffer geometry, widths,
// operation codes and the controller state type. No dependencies.
package mbfr_pkg;

	localparam int BUF_BYTES     = 4096;
	localparam int MAX_READ_BITS = 32;
	localparam int POS_W         = 16;
	localparam int ADDR_W        = $clog2(BUF_BYTES);
	localparam int LCNT_W        = $clog2(BUF_BYTES + 1);
	localparam int BASE_W        = POS_W - 3;
	localparam int CNT_W         = $clog2(MAX_READ_BITS + 1);
	// A read of MAX_READ_BITS bits at any bit offset touches at most this many bytes.
	localparam int WIN_BYTES     = (MAX_READ_BITS + 7 + 7) / 8;
	localparam int WIN_W         = WIN_BYTES * 8;
	localparam int SH_W          = $clog2(WIN_W + 1);
	localparam int K_W           = $clog2(WIN_BYTES);
	localparam int MASK_W        = MAX_READ_BITS + 1;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_READ    = 2'd1,
		OP_SKIP    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_DRAIN,
		S_EMIT
	} state_t;

endpackage

// File: hdl/msb_first_bit_field_reader.sv
// MSB-first bit field reader: byte memory, bit position and read controller.
// Depends on mbfr_pkg.
//
// Usage. Requests arrive on the input channel (in_valid / in_ready) with an
// operation code, a data byte and a bit count. A load appends data_byte to
// the byte buffer (ignored once the buffer is full). A skip advances the bit
// position by bit_count. A restart clears the position and the load count.
// A read extracts the next bit_count bits (clamped to 32) MSB first and
// returns one result on the output channel (out_valid / out_ready) with
// field_value right aligned, overrun and count_clamped.
//
// Timing. Load, skip and restart complete in the cycle they are accepted, so
// a new request can follow on the next clock. A read fetches five bytes from
// the byte memory, one per cycle, then aligns them: the result is registered
// in the emit state after the fetch and drain states, and no new request is
// taken before that, so reads do not overlap.
//
// Reset clears the position, the load count, the controller and the output
// valid flag; buffer contents are not cleared and are only used once loaded.
// A stalled receiver does not block loads, skips or restarts while no read
// is in flight; a read that finishes while the previous result is still
// waiting holds in its final stage until the output register frees up, and
// no request is taken meanwhile.
module msb_first_bit_field_reader
	import mbfr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic [7:0]               data_byte,
	input  logic [7:0]               bit_count,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [MAX_READ_BITS-1:0] field_value,
	output logic                     overrun,
	output logic                     count_clamped
);

	// Byte buffer, written at the load count and read one byte a cycle.
	logic [7:0] mem [BUF_BYTES];

	state_t state_q, state_d;

	logic [POS_W-1:0]  pos_q;
	logic [LCNT_W-1:0] lcnt_q;

	// Context of the read in flight.
	logic [BASE_W-1:0] base_q;
	logic [2:0]        off_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              over_q;
	logic              clamp_q;
	logic [K_W-1:0]    k_q;
	logic [WIN_W-1:0]  win_q;

	// Memory read pipeline.
	logic [7:0] rd_data_s1;
	logic       fetch_s1;
	logic       ok_s1;

	// Output register.
	logic                     out_valid_q;
	logic [MAX_READ_BITS-1:0] field_value_q;
	logic                     overrun_q;
	logic                     clamp_out_q;

	// Request decode.
	op_t              op;
	logic             accept;
	logic             mem_we;
	logic             rd_en;
	logic             fetch_last;
	logic             emit;
	logic             out_free;
	logic [CNT_W-1:0] rd_cnt;
	logic             rd_clamp;
	logic [7:0]       adv;
	logic [POS_W:0]   pos_sum;
	logic [POS_W:0]   last_bit;
	logic             rd_over;
	logic [BASE_W:0]  fetch_idx;

	// Alignment of the collected window.
	logic [SH_W-1:0]          sh;
	logic [WIN_W-1:0]         win_sh;
	logic [MASK_W-1:0]        mask;
	logic [MAX_READ_BITS-1:0] value;

	assign op       = op_t'(operation);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign rd_clamp = bit_count > 8'(MAX_READ_BITS);
	assign rd_cnt   = rd_clamp ? CNT_W'(MAX_READ_BITS) : bit_count[CNT_W-1:0];

	// Skips advance by the raw count, reads by the clamped count; both saturate.
	assign adv     = (op == OP_READ) ? 8'(rd_cnt) : bit_count;
	assign pos_sum = {1'b0, pos_q} + (POS_W + 1)'(adv);

	// A read overruns when its last bit lies in a byte beyond the loaded ones.
	assign last_bit = {1'b0, pos_q} + (POS_W + 1)'(rd_cnt) - (POS_W + 1)'(1);
	assign rd_over  = (rd_cnt != '0) &&
		(last_bit[POS_W:3] >= (POS_W - 2)'(lcnt_q));

	assign mem_we    = accept && (op == OP_LOAD) && (lcnt_q < LCNT_W'(BUF_BYTES));
	assign fetch_idx = {1'b0, base_q} + (BASE_W + 1)'(k_q);
	assign fetch_last = (k_q == K_W'(WIN_BYTES - 1));

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		emit     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && op == OP_READ) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				rd_en = 1'b1;
				if (fetch_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Position and load count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			lcnt_q <= '0;
		end else if (accept) begin
			case (op)
				OP_LOAD: begin
					if (mem_we) begin
						lcnt_q <= lcnt_q + LCNT_W'(1);
					end
				end
				OP_READ, OP_SKIP: begin
					pos_q <= pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
				end
				OP_RESTART: begin
					pos_q  <= '0;
					lcnt_q <= '0;
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	// Read context, captured with the old position at acceptance.
	always_ff @(posedge clk) begin
		if (accept && op == OP_READ) begin
			base_q  <= pos_q[POS_W-1:3];
			off_q   <= pos_q[2:0];
			cnt_q   <= rd_cnt;
			over_q  <= rd_over;
			clamp_q <= rd_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			fetch_s1 <= 1'b0;
		end else begin
			fetch_s1 <= rd_en;
			if (rd_en) begin
				k_q <= fetch_last ? '0 : k_q + K_W'(1);
			end
		end
	end

	// Byte memory: one write port for loads, one registered read for fetches.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[lcnt_q[ADDR_W-1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[fetch_idx[ADDR_W-1:0]];
			ok_s1      <= fetch_idx < (BASE_W + 1)'(lcnt_q);
		end
	end

	// Bytes beyond the loaded range enter the window as zeros.
	always_ff @(posedge clk) begin
		if (fetch_s1) begin
			win_q <= {win_q[WIN_W-9:0], ok_s1 ? rd_data_s1 : 8'd0};
		end
	end

	// The field ends (WIN_W - off - cnt) bits above the window's LSB.
	assign sh     = SH_W'(WIN_W) - SH_W'(off_q) - SH_W'(cnt_q);
	assign win_sh = win_q >> sh;
	assign mask   = (MASK_W'(1) << cnt_q) - MASK_W'(1);
	assign value  = win_sh[MAX_READ_BITS-1:0] & mask[MAX_READ_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			field_value_q <= value;
			overrun_q     <= over_q;
			clamp_out_q   <= clamp_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign field_value   = field_value_q;
	assign overrun       = overrun_q;
	assign count_clamped = clamp_out_q;

	// The load count never passes the buffer size.
	a_lcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q <= LCNT_W'(BUF_BYTES))
		else $error("load count beyond buffer size");

	// The buffer is never written while a read is fetching from it.
	a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_IDLE)
		else $error("buffer write during a read");

	// The last fetch's data lands in the window before alignment.
	a_drain_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> fetch_s1 ##1 state_q == S_EMIT)
		else $error("window not complete at alignment");

	// A result is only registered when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

endmodule
